// ===== sv/ble_pkg.sv =====
package ble_pkg;

  localparam int WINDOW_DEF = 60;

  localparam int CV_W     = 10;
  localparam int MA_W     = 12;
  localparam int GAIN_W   = 8;
  localparam int THR_W    = 11;
  localparam int SAMPLE_W = 11;
  localparam int LEVEL_W  = 3;

  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // gain * current + half of the divisor
  localparam int PROD_W = 20;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(500);

  // floor(x / 1000) == (x * RECIP_1000) >> DIV_SHIFT for every x below 2**20
  localparam int DIV_SHIFT = 30;
  localparam int RECIP_W   = 21;
  localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(1073742);
  localparam int QUOT_W    = 11;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(2047);

  localparam logic [THR_W-1:0]  THR_FOUR_RST  = THR_W'(386);
  localparam logic [THR_W-1:0]  THR_THREE_RST = THR_W'(372);
  localparam logic [THR_W-1:0]  THR_TWO_RST   = THR_W'(361);
  localparam logic [THR_W-1:0]  THR_ONE_RST   = THR_W'(330);
  localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(12);

  localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LEVEL_TWO   = LEVEL_W'(2);
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = LEVEL_W'(3);
  localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = LEVEL_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH_FOUR  = 3'd0,
    CFG_THRESH_THREE = 3'd1,
    CFG_THRESH_TWO   = 3'd2,
    CFG_THRESH_ONE   = 3'd3,
    CFG_COMP_GAIN    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr_four;
    logic [THR_W-1:0]  thr_three;
    logic [THR_W-1:0]  thr_two;
    logic [THR_W-1:0]  thr_one;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] comp;
    logic                charging;
  } comp_item_t;

  typedef struct packed {
    logic full;
    logic charging;
  } ring_flags_t;

endpackage

// ===== sv/ble_ram.sv =====
module ble_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ble_comp.sv =====
module ble_comp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ble_pkg::GAIN_W-1:0]  gain,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ble_pkg::CV_W-1:0]    battery_cv,
  input  logic [ble_pkg::MA_W-1:0]    motor_ma,
  input  logic                        charging,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ble_pkg::comp_item_t         out_item
);

  localparam int QP_W = ble_pkg::PROD_W + ble_pkg::RECIP_W;

  logic                          a_valid;
  logic [ble_pkg::CV_W-1:0]      a_cv;
  logic [ble_pkg::MA_W-1:0]      a_ma;
  logic                          a_chg;
  logic                          b_valid;
  logic [ble_pkg::PROD_W-1:0]    b_prod;
  logic [ble_pkg::CV_W-1:0]      b_cv;
  logic                          b_chg;
  logic                          a_free;
  logic                          b_free;
  logic                          c_free;
  logic [ble_pkg::PROD_W-1:0]    prod_next;
  logic [QP_W-1:0]               quot_prod;
  logic [ble_pkg::QUOT_W-1:0]    quot;
  logic [ble_pkg::SAMPLE_W:0]    comp_sum;
  logic [ble_pkg::SAMPLE_W-1:0]  comp_next;

  assign c_free   = !out_valid || out_ready;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free;

  // gain * current, rounded half up before the divide by 1000
  assign prod_next = ble_pkg::PROD_W'(gain) * ble_pkg::PROD_W'(a_ma) + ble_pkg::ROUND_HALF;

  assign quot_prod = QP_W'(b_prod) * QP_W'(ble_pkg::RECIP_1000);
  assign quot      = quot_prod[ble_pkg::DIV_SHIFT +: ble_pkg::QUOT_W];
  assign comp_sum  = (ble_pkg::SAMPLE_W + 1)'(b_cv) + (ble_pkg::SAMPLE_W + 1)'(quot);
  assign comp_next = (comp_sum > (ble_pkg::SAMPLE_W + 1)'(ble_pkg::SAMPLE_MAX)) ?
                     ble_pkg::SAMPLE_MAX : comp_sum[ble_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= in_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (c_free) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_cv  <= battery_cv;
      a_ma  <= motor_ma;
      a_chg <= charging;
    end
    if (b_free) begin
      b_prod <= prod_next;
      b_cv   <= a_cv;
      b_chg  <= a_chg;
    end
    if (c_free) begin
      out_item.comp     <= comp_next;
      out_item.charging <= b_chg;
    end
  end

endmodule

// ===== sv/ble_ring.sv =====
module ble_ring #(
  parameter int WINDOW = ble_pkg::WINDOW_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  ble_pkg::comp_item_t                             in_item,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [ble_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]     out_sum,
  output ble_pkg::ring_flags_t                            out_flags
);

  localparam int AW    = $clog2(WINDOW);
  localparam int SUM_W = ble_pkg::SAMPLE_W + AW;

  logic [AW-1:0]                wptr;
  logic [AW-1:0]                wptr_next;
  logic                         full;
  logic                         full_next;
  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             sum_next;
  logic [ble_pkg::SAMPLE_W-1:0] old_sample;
  logic                         xfer;
  logic                         wrap;

  assign in_ready = !out_valid || out_ready;
  assign xfer     = in_valid && in_ready;
  assign wrap     = (wptr == AW'(WINDOW - 1));

  // read address runs one slot ahead so the oldest sample is ready for the next item
  always_comb begin
    wptr_next = wptr;
    full_next = full;
    sum_next  = sum;
    if (xfer) begin
      wptr_next = wrap ? '0 : wptr + AW'(1);
      full_next = full || wrap;
      sum_next  = (full ? sum - SUM_W'(old_sample) : sum) + SUM_W'(in_item.comp);
    end
  end

  ble_ram #(
    .WIDTH (ble_pkg::SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (xfer),
    .waddr (wptr),
    .wdata (in_item.comp),
    .raddr (wptr_next),
    .rdata (old_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      full      <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      wptr <= wptr_next;
      full <= full_next;
      sum  <= sum_next;
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_sum            <= sum_next;
      out_flags.full     <= full_next;
      out_flags.charging <= in_item.charging;
    end
  end

endmodule

// ===== sv/ble_level.sv =====
module ble_level #(
  parameter int WINDOW = ble_pkg::WINDOW_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  ble_pkg::cfg_t                               cfg,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [ble_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] in_sum,
  input  ble_pkg::ring_flags_t                        in_flags,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [ble_pkg::LEVEL_W-1:0]                 level,
  output logic                                        window_full
);

  localparam int AW     = $clog2(WINDOW);
  localparam int SUM_W  = ble_pkg::SAMPLE_W + AW;
  localparam int SHIFT  = SUM_W + AW;
  localparam int RCP_W  = SUM_W + 2;
  localparam int MUL_W  = SUM_W + RCP_W;
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);

  logic                           d_valid;
  logic [ble_pkg::SAMPLE_W-1:0]   d_avg;
  ble_pkg::ring_flags_t           d_flags;
  logic                           d_free;
  logic                           o_free;
  logic [MUL_W-1:0]               avg_prod;
  logic [ble_pkg::LEVEL_W-1:0]    mapped;

  assign o_free   = !out_valid || out_ready;
  assign d_free   = !d_valid || o_free;
  assign in_ready = d_free;

  // truncating divide by the window length
  assign avg_prod = MUL_W'(in_sum) * MUL_W'(RECIP);

  always_comb begin
    if (d_avg >= cfg.thr_four) begin
      mapped = ble_pkg::LEVEL_FOUR;
    end else if (d_avg >= cfg.thr_three) begin
      mapped = ble_pkg::LEVEL_THREE;
    end else if (d_avg >= cfg.thr_two) begin
      mapped = ble_pkg::LEVEL_TWO;
    end else if (d_avg >= cfg.thr_one) begin
      mapped = ble_pkg::LEVEL_ONE;
    end else begin
      mapped = ble_pkg::LEVEL_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid     <= 1'b0;
      out_valid   <= 1'b0;
      level       <= ble_pkg::LEVEL_FOUR;
      window_full <= 1'b0;
    end else begin
      if (d_free) begin
        d_valid <= in_valid;
      end
      if (o_free) begin
        out_valid <= d_valid;
      end
      if (d_valid && o_free) begin
        window_full <= d_flags.full;
        // level only drops unless charging
        if (d_flags.full && (d_flags.charging || mapped < level)) begin
          level <= mapped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_free) begin
      d_avg   <= avg_prod[SHIFT +: ble_pkg::SAMPLE_W];
      d_flags <= in_flags;
    end
  end

endmodule

// ===== sv/battery_level_estimator.sv =====
// channel  direction  payload
// s_*      in         tdata: battery_cv, motor_ma; tuser: charging
// m_*      out        tdata: level; tuser: window_full
// cfg_*    in         cfg_index selects register, cfg_data is the value
//
// one item per cycle sustained while m_tready is high; a result is registered in turn
// by comp a, b, out, the ring output and level d, out, which hold the gain multiply,
// the divide by 1000, the ring memory read/update and the divide by the window length
// rst clears pointer, sum, fill flag and level (4); the ring needs no clearing
// a stalled m side fills the pipeline bubbles first, then holds s_tready low
module battery_level_estimator #(
  parameter int WINDOW = ble_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ble_pkg::S_DATA_W-1:0]    s_tdata,   // battery_cv, motor_ma, zero pad
  input  logic                            s_tuser,   // charging
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ble_pkg::M_DATA_W-1:0]    m_tdata,   // level, zero pad
  output logic                            m_tuser,   // window_full
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ble_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ble_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam int SUM_W = ble_pkg::SAMPLE_W + $clog2(WINDOW);

  ble_pkg::cfg_t               cfg;
  ble_pkg::comp_item_t         comp_item;
  ble_pkg::ring_flags_t        ring_flags;
  logic                        comp_valid;
  logic                        comp_ready;
  logic                        ring_valid;
  logic                        ring_ready;
  logic [SUM_W-1:0]            ring_sum;
  logic [ble_pkg::LEVEL_W-1:0] level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_four  <= ble_pkg::THR_FOUR_RST;
      cfg.thr_three <= ble_pkg::THR_THREE_RST;
      cfg.thr_two   <= ble_pkg::THR_TWO_RST;
      cfg.thr_one   <= ble_pkg::THR_ONE_RST;
      cfg.gain      <= ble_pkg::GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ble_pkg::cfg_index_t'(cfg_index))
        ble_pkg::CFG_THRESH_FOUR:  cfg.thr_four  <= cfg_data;
        ble_pkg::CFG_THRESH_THREE: cfg.thr_three <= cfg_data;
        ble_pkg::CFG_THRESH_TWO:   cfg.thr_two   <= cfg_data;
        ble_pkg::CFG_THRESH_ONE:   cfg.thr_one   <= cfg_data;
        ble_pkg::CFG_COMP_GAIN:    cfg.gain      <= cfg_data[ble_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ble_comp u_comp (
    .clk        (clk),
    .rst        (rst),
    .gain       (cfg.gain),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .battery_cv (s_tdata[ble_pkg::CV_W-1:0]),
    .motor_ma   (s_tdata[ble_pkg::CV_W +: ble_pkg::MA_W]),
    .charging   (s_tuser),
    .out_valid  (comp_valid),
    .out_ready  (comp_ready),
    .out_item   (comp_item)
  );

  ble_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (comp_valid),
    .in_ready  (comp_ready),
    .in_item   (comp_item),
    .out_valid (ring_valid),
    .out_ready (ring_ready),
    .out_sum   (ring_sum),
    .out_flags (ring_flags)
  );

  ble_level #(
    .WINDOW (WINDOW)
  ) u_level (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (ring_valid),
    .in_ready    (ring_ready),
    .in_sum      (ring_sum),
    .in_flags    (ring_flags),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .level       (level),
    .window_full (m_tuser)
  );

  assign m_tdata = ble_pkg::M_DATA_W'(level);

endmodule

// ===== sv/ble_checker.sv =====
module ble_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ble_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                          m_tuser
);

  logic seen_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_full <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser) begin
      seen_full <= 1'b1;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ble_pkg::LEVEL_W-1:0] <= ble_pkg::LEVEL_FOUR))
    else $error("level out of range");

  a_level_before_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[ble_pkg::LEVEL_W-1:0] == ble_pkg::LEVEL_FOUR))
    else $error("level changed before window filled");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && seen_full) |-> m_tuser)
    else $error("window_full dropped after being reported");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind battery_level_estimator ble_checker u_ble_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
